/* rtl/hit_record_unpacker_macros.svh */
// Assertion macros shared by the hit record unpacker RTL.
// Needs i_clk and i_rst_n in the module that uses them; empty when SYNTHESIS is set.
`ifndef HIT_RECORD_UNPACKER_MACROS_SVH
`define HIT_RECORD_UNPACKER_MACROS_SVH

`ifndef SYNTHESIS
`define HRU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define HRU_ASSERT_NEVER(label, cond, msg) \
    `HRU_ASSERT(label, !(cond), msg)
`else
`define HRU_ASSERT(label, prop, msg)
`define HRU_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* rtl/hru_pkg.sv */
// Types and constants of the hit record unpacker.
// Used by hru_front, hru_fifo, hru_back and hit_record_unpacker; no dependencies.
package hru_pkg;

    localparam int MAX_CARDS          = 8;
    localparam int CHANNELS_PER_BOARD = 32;

    localparam int CARD_COUNT_W = 4;
    localparam int BOARD_CNTS_W = 64;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 1;
    localparam int LONGS_W      = 31;   // a block count never has bit 31 set

    localparam logic [CFG_IDX_W-1:0] CFG_CARD_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_COUNTS = 1'b1;

    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic [15:0] data_word;
        logic        buffer_end;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  channel;
        logic [7:0]  board;
        logic [7:0]  card;
        logic [7:0]  trigger_id;
        logic [15:0] energy;
        logic [15:0] hit_time;
        logic        mapped;
        logic        block_end;
    } t_result;

    // classified record passed from front to back
    typedef struct packed {
        logic        kind;
        logic [31:0] designator;
        logic [31:0] value;
        logic        block_end;
    } t_task;

endpackage

/* rtl/hru_front.sv */
// Front end: pairs 16-bit words into longwords, tracks the block and classifies records.
// Depends on hru_pkg and hit_record_unpacker_macros.svh.
`include "hit_record_unpacker_macros.svh"

module hru_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  hru_pkg::t_in_item i_item,
    output logic              o_push,
    output hru_pkg::t_task    o_task
);
    import hru_pkg::*;

    logic               r_half_held, n_half_held;
    logic [15:0]        r_low_half,  n_low_half;
    logic               r_in_block,  n_in_block;
    logic               r_desig_held, n_desig_held;
    logic [31:0]        r_designator, n_designator;
    logic [LONGS_W-1:0] r_longs_left, n_longs_left;
    logic [31:0]        lw;

    always_comb begin
        n_half_held  = r_half_held;
        n_low_half   = r_low_half;
        n_in_block   = r_in_block;
        n_desig_held = r_desig_held;
        n_designator = r_designator;
        n_longs_left = r_longs_left;
        o_push       = 1'b0;
        o_task       = '0;
        lw           = {i_item.data_word, r_low_half};
        if (i_accept) begin
            if (!r_half_held) begin
                n_low_half  = i_item.data_word;
                n_half_held = 1'b1;
            end else begin
                n_half_held = 1'b0;
                if (!r_in_block) begin
                    // zero or negative count: empty block
                    if (lw != 32'd0 && !lw[31]) begin
                        n_longs_left = lw[LONGS_W-1:0];
                        n_in_block   = 1'b1;
                        n_desig_held = 1'b0;
                    end
                end else if (!r_desig_held) begin
                    n_designator = lw;
                    n_desig_held = 1'b1;
                    n_longs_left = r_longs_left - 1'b1;
                end else begin
                    n_desig_held = 1'b0;
                    o_push       = 1'b1;
                    if (r_longs_left == '0) begin
                        // count ran out after the designator
                        o_task.kind      = KIND_ERROR;
                        o_task.block_end = 1'b1;
                        n_in_block       = 1'b0;
                    end else begin
                        o_task.kind       = KIND_HIT;
                        o_task.designator = r_designator;
                        o_task.value      = lw;
                        n_longs_left      = r_longs_left - 1'b1;
                        if (r_longs_left == LONGS_W'(1)) begin
                            o_task.block_end = 1'b1;
                            n_in_block       = 1'b0;
                        end
                    end
                end
            end
            if (i_item.buffer_end) begin
                n_in_block   = 1'b0;
                n_half_held  = 1'b0;
                n_desig_held = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_held  <= 1'b0;
            r_in_block   <= 1'b0;
            r_desig_held <= 1'b0;
            r_longs_left <= '0;
        end else begin
            r_half_held  <= n_half_held;
            r_in_block   <= n_in_block;
            r_desig_held <= n_desig_held;
            r_longs_left <= n_longs_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low_half   <= n_low_half;
        r_designator <= n_designator;
    end

    `HRU_ASSERT(a_buf_end_clears, i_accept && i_item.buffer_end |=> !r_half_held && !r_in_block && !r_desig_held, "buffer end left stream state")
    `HRU_ASSERT_NEVER(a_desig_outside_block, r_desig_held && !r_in_block, "designator held outside a block")

endmodule

/* rtl/hru_fifo.sv */
// Short queue of classified records between front and back.
// Depends on hru_pkg and hit_record_unpacker_macros.svh; DEPTH is a power of two, at least 2.
`include "hit_record_unpacker_macros.svh"

module hru_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hru_pkg::t_task i_data,
    output logic           o_full,
    input  logic           i_pop,
    output hru_pkg::t_task o_data,
    output logic           o_empty
);
    import hru_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_task            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `HRU_ASSERT_NEVER(a_push_full, i_push && o_full, "push into full queue")
    `HRU_ASSERT_NEVER(a_pop_empty, i_pop && o_empty, "pop from empty queue")

endmodule

/* rtl/hru_back.sv */
// Back end: checks the mapping of each record and holds it in the output register.
// Depends on hru_pkg and hit_record_unpacker_macros.svh.
`include "hit_record_unpacker_macros.svh"

module hru_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [hru_pkg::CARD_COUNT_W-1:0] i_card_count,
    input  logic [hru_pkg::BOARD_CNTS_W-1:0] i_board_counts,
    input  hru_pkg::t_task                   i_task,
    input  logic                             i_task_empty,
    output logic                             o_task_pop,
    input  logic                             i_pop,
    output logic                             o_empty,
    output hru_pkg::t_result                 o_result
);
    import hru_pkg::*;

    logic                    r_out_valid;
    t_result                 r_out;
    t_result                 n_out;
    logic [CARD_COUNT_W-1:0] cards;
    logic [5:0]              bc_sel;
    logic [7:0]              nboards;
    logic                    mapped;

    // card count saturates at MAX_CARDS
    assign cards   = (i_card_count > CARD_COUNT_W'(MAX_CARDS))
                     ? CARD_COUNT_W'(MAX_CARDS) : i_card_count;
    assign bc_sel  = {i_task.designator[18:16], 3'b000};
    assign nboards = i_board_counts[bc_sel +: 8];
    assign mapped  = (i_task.kind == KIND_HIT)
                     && (i_task.designator[23:16] < {4'b0000, cards})
                     && (i_task.designator[15:8] < nboards)
                     && ({1'b0, i_task.designator[7:0]} < 9'(CHANNELS_PER_BOARD));

    always_comb begin
        n_out.kind       = i_task.kind;
        n_out.channel    = i_task.designator[7:0];
        n_out.board      = i_task.designator[15:8];
        n_out.card       = i_task.designator[23:16];
        n_out.trigger_id = i_task.designator[31:24];
        n_out.energy     = i_task.value[31:16];
        n_out.hit_time   = i_task.value[15:0];
        n_out.mapped     = mapped;
        n_out.block_end  = i_task.block_end;
    end

    // load when the output register is free or being drained this cycle
    assign o_task_pop = !i_task_empty && (!r_out_valid || i_pop);
    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_task_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_task_pop) begin
            r_out <= n_out;
        end
    end

    `HRU_ASSERT_NEVER(a_err_fields, r_out_valid && r_out.kind == KIND_ERROR && (r_out.mapped || !r_out.block_end), "error record malformed")

endmodule

/* rtl/hit_record_unpacker.sv */
// Hit record unpacker: one 16-bit word per cycle while the queue is not full; a result
// reaches the result ports through the record queue and the output register.
// Throughput is one word per cycle while the queue is not full, set by the front end's pairing logic;
// the record queue of FIFO_DEPTH entries absorbs result-side stalls.
// Synchronous active-low reset clears the stream state, the queue, the output
// valid flag and both configuration registers; no clearing pass.
// Depends on hru_pkg, hru_front, hru_fifo and hru_back.
module hit_record_unpacker #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  hru_pkg::t_in_item              i_item,
    output logic                           empty,
    input  logic                           pop,
    output hru_pkg::t_result               o_result,
    input  logic                           i_cfg_we,
    input  logic [hru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hru_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hru_pkg::*;

    logic [CARD_COUNT_W-1:0] r_card_count;
    logic [BOARD_CNTS_W-1:0] r_board_counts;
    logic                    accept;
    logic                    front_push;
    t_task                   front_task;
    t_task                   q_task;
    logic                    q_empty;
    logic                    q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_count   <= '0;
            r_board_counts <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CARD_COUNT:   r_card_count   <= i_cfg_data[CARD_COUNT_W-1:0];
                CFG_BOARD_COUNTS: r_board_counts <= i_cfg_data[BOARD_CNTS_W-1:0];
                default:          r_card_count   <= r_card_count;
            endcase
        end
    end

    assign accept = push && !full;

    hru_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (front_push),
        .o_task   (front_task)
    );

    hru_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_task),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_task),
        .o_empty (q_empty)
    );

    hru_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_card_count   (r_card_count),
        .i_board_counts (r_board_counts),
        .i_task         (q_task),
        .i_task_empty   (q_empty),
        .o_task_pop     (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result       (o_result)
    );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for hit_record_unpacker: random queue-side stalls on both ports,
// an in-bench decoder of the word stream predicts every hit and error record.
// Depends on hru_pkg and the hit_record_unpacker RTL.
module testbench;
    import hru_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_item              i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    hit_record_unpacker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // mapping registers as the block should hold them
    logic [3:0]  card_cnt = '0;
    logic [63:0] board_cnts = '0;

    // stream decoder state
    logic        stream_open = 1'b0;
    logic        half_valid = 1'b0;
    logic [15:0] held_low = '0;
    logic        desig_valid = 1'b0;
    logic [31:0] desig = '0;
    logic [31:0] longs_left = '0;

    t_result     records_due[$];
    int unsigned words_sent = 0;
    int unsigned mismatches = 0;
    int unsigned in_gap_max = 18;
    int unsigned out_gap_max = 18;
    int unsigned hold_off = 0;

    initial begin
        #5_000_000;
        $display("hit_record_unpacker: mismatch");
        $finish;
    end

    function automatic logic in_mapping(input logic [7:0] chan, input logic [7:0] brd,
                                        input logic [7:0] crd);
        logic [3:0] cards;
        logic [7:0] boards;
        cards = (card_cnt > MAX_CARDS) ? 4'(MAX_CARDS) : card_cnt;
        if (crd >= cards) return 1'b0;
        boards = board_cnts[8*crd[2:0] +: 8];
        return (brd < boards) && (chan < CHANNELS_PER_BOARD);
    endfunction

    task automatic reset_stream();
        stream_open = 1'b0;
        half_valid  = 1'b0;
        held_low    = '0;
        desig_valid = 1'b0;
        desig       = '0;
        longs_left  = '0;
    endtask

    // one accepted word; queues the record it completes, if any
    task automatic decode_word(input logic [15:0] word, input logic last);
        logic [31:0] lw;
        t_result rec;
        if (!half_valid) begin
            held_low   = word;
            half_valid = 1'b1;
        end else begin
            lw = {word, held_low};
            half_valid = 1'b0;
            held_low   = '0;
            if (!stream_open) begin
                // zero or negative count: empty block
                if (lw != 0 && !lw[31]) begin
                    longs_left  = lw;
                    stream_open = 1'b1;
                    desig_valid = 1'b0;
                end
            end else if (!desig_valid) begin
                desig       = lw;
                desig_valid = 1'b1;
                longs_left--;
            end else begin
                desig_valid = 1'b0;
                rec = '0;
                if (longs_left == 0) begin
                    // count ran out after the designator
                    rec.kind      = KIND_ERROR;
                    rec.block_end = 1'b1;
                    reset_stream();
                end else begin
                    longs_left--;
                    rec.kind       = KIND_HIT;
                    rec.channel    = desig[7:0];
                    rec.board      = desig[15:8];
                    rec.card       = desig[23:16];
                    rec.trigger_id = desig[31:24];
                    rec.energy     = lw[31:16];
                    rec.hit_time   = lw[15:0];
                    rec.mapped     = in_mapping(desig[7:0], desig[15:8], desig[23:16]);
                    if (longs_left == 0) begin
                        rec.block_end = 1'b1;
                        reset_stream();
                    end
                end
                records_due.insert(records_due.size(), rec);
            end
        end
        if (last) reset_stream();
    endtask

    task automatic cmp_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_record(input t_result got);
        t_result want;
        if (records_due.size() == 0) begin
            $display("%0t: record expected none actual %h", $time, got);
            mismatches++;
            return;
        end
        want = records_due.pop_front();
        cmp_field("kind", 16'(want.kind), 16'(got.kind));
        cmp_field("channel", 16'(want.channel), 16'(got.channel));
        cmp_field("board", 16'(want.board), 16'(got.board));
        cmp_field("card", 16'(want.card), 16'(got.card));
        cmp_field("trigger_id", 16'(want.trigger_id), 16'(got.trigger_id));
        cmp_field("energy", want.energy, got.energy);
        cmp_field("hit_time", want.hit_time, got.hit_time);
        cmp_field("mapped", 16'(want.mapped), 16'(got.mapped));
        cmp_field("block_end", 16'(want.block_end), 16'(got.block_end));
    endtask

    // result side: random pop gaps, plus a long hold-off on request
    initial begin : result_sink
        int unsigned wait_cycles;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off != 0) begin
                wait_cycles = hold_off;
                hold_off = 0;
            end else begin
                wait_cycles = $urandom_range(0, out_gap_max);
            end
            if (wait_cycles != 0) begin
                pop <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            check_record(o_result);
        end
    end

    // push stays high on return so back-to-back beats need no extra edge
    task automatic send_word(input logic [15:0] word, input logic last);
        int unsigned gap;
        t_in_item beat;
        gap = $urandom_range(0, in_gap_max);
        beat.data_word  = word;
        beat.buffer_end = last;
        @(negedge i_clk);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= beat;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
        decode_word(word, last);
    endtask

    task automatic send_long(input logic [31:0] lw, input logic last);
        send_word(lw[15:0], 1'b0);
        send_word(lw[31:16], last);
    endtask

    // lower push, let every record drain, then give the pipeline time to go quiet
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        while (records_due.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_CARD_COUNT) card_cnt = data[3:0];
        else board_cnts = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mapping(input logic [63:0] cards, input logic [63:0] boards);
        write_reg(CFG_CARD_COUNT, cards);
        write_reg(CFG_BOARD_COUNTS, boards);
    endtask

    // mostly near the mapping edges, sometimes anywhere
    function automatic logic [31:0] rand_designator();
        logic [7:0] chan, brd, crd;
        chan = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
        brd  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        crd  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
        return {8'($urandom), crd, brd, chan};
    endfunction

    function automatic logic [63:0] small_board_counts();
        logic [63:0] bc;
        for (int k = 0; k < 8; k++) bc[8*k +: 8] = 8'($urandom_range(0, 12));
        return bc;
    endfunction

    task automatic send_block(input logic [31:0] count, input int pairs, input bit close_buf);
        send_long(count, 1'b0);
        for (int p = 0; p < pairs; p++) begin
            send_long(rand_designator(), 1'b0);
            send_long($urandom, close_buf && p == pairs - 1);
        end
    endtask

    task automatic run_traffic(input int unsigned n_words);
        int unsigned stop_at;
        int pairs;
        logic [31:0] lw;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            pairs = $urandom_range(1, 6);
            case ($urandom_range(0, 19))
                15: begin
                    // empty or negative count
                    lw = $urandom_range(0, 1) ? 32'h0 : ($urandom | 32'h8000_0000);
                    send_long(lw, 1'b0);
                end
                16: send_block(32'(2*pairs + 2*$urandom_range(1, 3)), pairs, 1'b1);
                17: begin
                    // buffer closes on a low half inside a block
                    send_block(32'(2*pairs + 4), pairs, 1'b0);
                    send_word(16'($urandom), 1'b1);
                end
                18: begin
                    repeat ($urandom_range(1, 12))
                        send_word(16'($urandom), $urandom_range(0, 7) == 0);
                    send_word(16'($urandom), 1'b1);
                end
                19: begin
                    send_block($urandom & 32'h7fff_ffff | 32'h100, pairs, 1'b0);
                    send_word(16'($urandom), 1'b1);
                end
                13, 14: send_block(32'(2*pairs - 1), pairs, 1'b0);
                default: send_block(32'(2*pairs), pairs, $urandom_range(0, 3) == 0);
            endcase
        end
    endtask

    task automatic test_reset_mapping();
        in_gap_max  = 18;
        out_gap_max = 18;
        run_traffic(150);
        settle();
    endtask

    task automatic test_directed_cases();
        in_gap_max  = 3;
        out_gap_max = 3;
        // card 0 has two boards, card 1 three
        set_mapping(64'd2, 64'h0000_0000_0000_0302);
        send_long(32'h0000_0000, 1'b0);
        send_long(32'h8000_0001, 1'b0);
        // all-ones fields, buffer closes on the completing word
        send_long(32'd2, 1'b0);
        send_long(32'hffff_ffff, 1'b0);
        send_long(32'hffff_ffff, 1'b1);
        // count ends after the designator
        send_long(32'd1, 1'b0);
        send_long(32'h0001_0200, 1'b0);
        send_long(32'h1234_5678, 1'b0);
        // edge of the mapping, then a dropped partial designator
        send_long(32'd4, 1'b0);
        send_long(32'h0001_021f, 1'b0);
        send_long(32'h0000_0000, 1'b0);
        send_word(16'hffff, 1'b1);
        settle();
    endtask

    task automatic test_config_sweep();
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: begin
                    set_mapping(64'd8, 64'hffff_ffff_ffff_ffff);
                    in_gap_max = 18; out_gap_max = 18;
                end
                1: begin
                    // card count above the card limit saturates
                    set_mapping(64'hffff_ffff_ffff_ffff, small_board_counts());
                    in_gap_max = 0; out_gap_max = 0;
                end
                2: begin
                    set_mapping(64'd0, small_board_counts());
                    in_gap_max = 0; out_gap_max = 18;
                end
                3: begin
                    set_mapping(64'd1, 64'h0000_0000_0000_0001);
                    in_gap_max = 18; out_gap_max = 0;
                end
                4: begin
                    set_mapping(64'd5, small_board_counts());
                    in_gap_max = 6; out_gap_max = 6;
                end
                default: begin
                    set_mapping(64'd8, {$urandom, $urandom});
                    in_gap_max = 18; out_gap_max = 18;
                end
            endcase
            run_traffic(270);
            settle();
        end
    endtask

    task automatic test_output_stall();
        int unsigned stop_at;
        set_mapping(64'd8, small_board_counts());
        in_gap_max  = 0;
        out_gap_max = 4;
        hold_off    = 300;
        stop_at     = words_sent + 160;
        while (words_sent < stop_at) send_block(32'd12, 6, 1'b0);
        settle();
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_mapping();
        test_directed_cases();
        test_config_sweep();
        test_output_stall();
        repeat (12) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("hit_record_unpacker: match");
        end else begin
            $display("hit_record_unpacker: mismatch");
        end
        $finish;
    end

endmodule
